// File: rtl/qsb_pkg.sv
// Package for the quaternion skinning blend block: word types, kind codes
// and fixed-point helpers. No dependencies.
`timescale 1ns / 1ps
package qsb_pkg;

  localparam int MAX_BONES_DEF = 1024;
  localparam int CNT_W = 11;
  localparam int IDX_W = 10;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_WGT  = 2'd1,
    KIND_LAST = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [IDX_W-1:0]   bone_index;
    logic signed [31:0] blend_weight;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
    logic signed [31:0] tan_x;
    logic signed [31:0] tan_y;
    logic signed [31:0] tan_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_norm_x;
    logic signed [31:0] out_norm_y;
    logic signed [31:0] out_norm_z;
    logic signed [31:0] out_tan_x;
    logic signed [31:0] out_tan_y;
    logic signed [31:0] out_tan_z;
    logic               bad_bone;
  } out_word_t;

  localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;

  function automatic logic signed [31:0] clampq(input logic signed [31:0] v);
    if (v > Q_ONE) return Q_ONE;
    if (v < -Q_ONE) return -Q_ONE;
    return v;
  endfunction

  // Q2.30 product: floor shift of the full product (arithmetic shift floors).
  function automatic logic signed [40:0] qmul(input logic signed [31:0] a,
                                              input logic signed [36:0] b);
    logic signed [68:0] p;
    p = 69'(a) * 69'(b);
    return 41'(p >>> 30);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) return 32'sh7fff_ffff;
    if (v < -43'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
    if (v > 42'sd549755813887) return 40'sh7f_ffff_ffff;
    if (v < -42'sd549755813888) return 40'sh80_0000_0000;
    return v[39:0];
  endfunction

endpackage

// File: rtl/quaternion_skinning_blend.sv
// Quaternion skinning blend: bone table in two RAMs, per-vertex sums.
// A load, an unused kind or a bad-bone weight is handled at acceptance; a good weight runs
// from acceptance through a RAM read, then three vectors times four steps: t, s, rotate,
// scale and add; no new word is taken until the weight is done and the block is idle.
// A last weight registers its result word into an output register in its final step;
// while that word waits, a last weight is held at the input or in its final step.
// rst_n clears control state, sums and the flag, and sets bone_count to 1; RAMs are kept.
`timescale 1ns / 1ps
module quaternion_skinning_blend
  import qsb_pkg::*;
#(
  parameter int MAX_BONES = MAX_BONES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_data,
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_wdata
);

  localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_T    = 6'b000100,
    S_S    = 6'b001000,
    S_R    = 6'b010000,
    S_A    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Bone RAMs: one row per bone, read into registers at acceptance.
  logic [95:0]  pos_mem [MAX_BONES];
  logic [127:0] rot_mem [MAX_BONES];
  logic [95:0]  pos_rd_r;
  logic [127:0] rot_rd_r;

  in_word_t           w_r;
  logic [1:0]         vec_r;    // which vector: position, normal, tangent
  logic [CNT_W-1:0]   bone_count_r;
  logic signed [39:0] sum_r [9];
  logic               err_r;
  logic signed [36:0] t_r [3];
  logic signed [36:0] s_r [3];
  logic signed [31:0] sc_r [3]; // rotated (and offset) vector, awaiting the weight
  logic               out_valid_r;
  out_word_t          out_r;

  logic in_acc, idx_ok, out_busy;
  logic [AW-1:0] in_addr;
  // the output word is busy when it waits and is not taken at this edge
  assign out_busy  = out_valid_r && !out_ready;
  assign in_ready  = (state_r == S_IDLE) && !(out_busy && in_data.kind == KIND_LAST);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_addr   = AW'(in_data.bone_index);
  assign idx_ok    = ({1'b0, in_data.bone_index} < bone_count_r) &&
                     (32'(in_data.bone_index) < MAX_BONES);

  // Write a loaded bone row; read the bone row at acceptance and hold it for the whole weight.
  always_ff @(posedge clk) begin
    if (in_acc && in_data.kind == KIND_LOAD && 32'(in_data.bone_index) < MAX_BONES) begin
      pos_mem[in_addr] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z};
      rot_mem[in_addr] <= {clampq(in_data.blend_weight), clampq(in_data.norm_x),
                           clampq(in_data.norm_y), clampq(in_data.norm_z)};
    end
    if (in_acc) begin
      pos_rd_r <= pos_mem[in_addr];
      rot_rd_r <= rot_mem[in_addr];
    end
  end

  // Quaternion and current vector selection.
  logic signed [31:0] qw, qx, qy, qz;
  logic signed [36:0] v [3];
  logic signed [36:0] a [3];  // operand vector of the cross product
  logic signed [40:0] c [3];
  logic signed [42:0] r [3];
  logic signed [31:0] rv [3];
  logic signed [31:0] sc [3];
  logic signed [31:0] wgt;
  assign {qw, qx, qy, qz} = rot_rd_r;
  assign wgt = clampq(w_r.blend_weight);

  always_comb begin
    unique case (vec_r)
      2'd0:    begin v[0] = 37'(w_r.pos_x);  v[1] = 37'(w_r.pos_y);  v[2] = 37'(w_r.pos_z);  end
      2'd1:    begin v[0] = 37'(w_r.norm_x); v[1] = 37'(w_r.norm_y); v[2] = 37'(w_r.norm_z); end
      default: begin v[0] = 37'(w_r.tan_x);  v[1] = 37'(w_r.tan_y);  v[2] = 37'(w_r.tan_z);  end
    endcase
    for (int i = 0; i < 3; i++) a[i] = (state_r == S_S) ? t_r[i] : v[i];
    c[0] = qmul(qy, a[2]) - qmul(qz, a[1]);
    c[1] = qmul(qz, a[0]) - qmul(qx, a[2]);
    c[2] = qmul(qx, a[1]) - qmul(qy, a[0]);
    for (int i = 0; i < 3; i++) begin
      r[i] = 43'(v[i]) + 43'(2 * (43'(qmul(qw, t_r[i])) + 43'(s_r[i])));
      rv[i] = sat32(r[i]);
    end
    sc[0] = sat32(43'(rv[0]) + 43'($signed(pos_rd_r[95:64])));
    sc[1] = sat32(43'(rv[1]) + 43'($signed(pos_rd_r[63:32])));
    sc[2] = sat32(43'(rv[2]) + 43'($signed(pos_rd_r[31:0])));
    if (vec_r != 2'd0) for (int i = 0; i < 3; i++) sc[i] = rv[i];
  end

  logic last_vec;
  logic a_hold;
  assign last_vec = (vec_r == 2'd2);
  // hold the final step of a last weight while the previous word still waits
  assign a_hold   = (state_r == S_A) && last_vec && w_r.kind == KIND_LAST && out_busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && (in_data.kind == KIND_WGT || in_data.kind == KIND_LAST))
                state_nxt = idx_ok ? S_READ : S_IDLE;
      S_READ: state_nxt = S_T;
      S_T:    state_nxt = S_S;
      S_S:    state_nxt = S_R;
      S_R:    state_nxt = S_A;
      S_A:    if (!a_hold) state_nxt = last_vec ? S_IDLE : S_T;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Emit a vertex word: from idle for a bad last weight, else after tangent.
  logic emit;
  logic emit_err;
  assign emit = (in_acc && in_data.kind == KIND_LAST && !idx_ok) ||
                (state_r == S_A && last_vec && w_r.kind == KIND_LAST && !out_busy);
  assign emit_err = err_r || (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bone_count_r <= CNT_W'(1);
      err_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      vec_r        <= 2'd0;
      for (int i = 0; i < 9; i++) sum_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) bone_count_r <= cfg_wdata;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (in_acc) begin
        w_r   <= in_data;
        vec_r <= 2'd0;
        if ((in_data.kind == KIND_WGT || in_data.kind == KIND_LAST) && !idx_ok)
          err_r <= 1'b1;
      end
      if (state_r == S_T) for (int i = 0; i < 3; i++) t_r[i] <= 37'(c[i]);
      if (state_r == S_S) for (int i = 0; i < 3; i++) s_r[i] <= 37'(c[i]);
      if (state_r == S_R) for (int i = 0; i < 3; i++) sc_r[i] <= sc[i];
      if (state_r == S_A && !a_hold) begin
        for (int i = 0; i < 3; i++)
          sum_r[3*vec_r + i] <= sat40(42'(sum_r[3*vec_r + i]) +
                                      42'(qmul(wgt, 37'(sc_r[i]))));
        vec_r <= vec_r + 2'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        err_r <= 1'b0;
        for (int i = 0; i < 9; i++) sum_r[i] <= '0;
      end
    end
  end

  // Output word: the final vector's term is folded in here.
  logic signed [39:0] fin [9];
  always_comb begin
    for (int i = 0; i < 9; i++) fin[i] = sum_r[i];
    if (state_r == S_A)
      for (int i = 0; i < 3; i++)
        fin[6 + i] = sat40(42'(sum_r[6 + i]) + 42'(qmul(wgt, 37'(sc_r[i]))));
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.out_pos_x  <= sat32(43'(fin[0]));
      out_r.out_pos_y  <= sat32(43'(fin[1]));
      out_r.out_pos_z  <= sat32(43'(fin[2]));
      out_r.out_norm_x <= sat32(43'(fin[3]));
      out_r.out_norm_y <= sat32(43'(fin[4]));
      out_r.out_norm_z <= sat32(43'(fin[5]));
      out_r.out_tan_x  <= sat32(43'(fin[6]));
      out_r.out_tan_y  <= sat32(43'(fin[7]));
      out_r.out_tan_z  <= sat32(43'(fin[8]));
      out_r.bad_bone   <= emit_err;
    end
  end

endmodule

// File: tb/sv/quaternion_skinning_blend_test.sv
// Self-checking testbench for quaternion_skinning_blend: a directed table, then
// random bone loads and vertex weight streams checked against a local predictor.
// Depends on qsb_pkg and the quaternion_skinning_blend RTL.
`timescale 1ns / 1ps
module quaternion_skinning_blend_test;
  import qsb_pkg::*;

  localparam int  NBONES     = 1024;
  localparam int  CYCLE_CAP  = 600000;
  localparam int  SETTLE     = 30;
  localparam longint UNIT    = 64'sd1073741824;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  // sideband travelling with the input word: a hand-typed result, if any
  logic      typed_on;
  out_word_t typed_word;

  quaternion_skinning_blend i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state: bone table, per-vertex sums, error flag, bone count
  int     pr_bpos[NBONES][3];
  int     pr_brot[NBONES][4];
  longint pr_spos[3], pr_snrm[3], pr_stan[3];
  bit     pr_err;
  int     pr_count;
  bit     loaded[NBONES];
  int     loaded_q[$];

  out_word_t vertex_q[$];
  int     mismatches, results_seen, words_sent, vertices_sent, cycles;
  int     tx_idle_pct, rx_idle_pct, rx_hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unit_clamp(longint v);
    if (v > UNIT) return UNIT;
    if (v < -UNIT) return -UNIT;
    return v;
  endfunction

  function automatic longint to32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint to40(longint v);
    if (v > 64'sd549755813887) return 64'sd549755813887;
    if (v < -64'sd549755813888) return -64'sd549755813888;
    return v;
  endfunction

  // Q2.30 product, floored (arithmetic shift on a signed longint floors)
  function automatic longint fix_mul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 30;
  endfunction

  // r = v + 2*(w*t + u x t), t = u x v
  task automatic quat_rotate(input longint q[4], input longint v[3], output longint r[3]);
    longint t[3], s[3];
    t[0] = fix_mul(q[2], v[2]) - fix_mul(q[3], v[1]);
    t[1] = fix_mul(q[3], v[0]) - fix_mul(q[1], v[2]);
    t[2] = fix_mul(q[1], v[1]) - fix_mul(q[2], v[0]);
    s[0] = fix_mul(q[2], t[2]) - fix_mul(q[3], t[1]);
    s[1] = fix_mul(q[3], t[0]) - fix_mul(q[1], t[2]);
    s[2] = fix_mul(q[1], t[1]) - fix_mul(q[2], t[0]);
    for (int i = 0; i < 3; i++) r[i] = to32(v[i] + 2 * (fix_mul(q[0], t[i]) + s[i]));
  endtask

  task automatic blend_word(input in_word_t w, output bit emits, output out_word_t o);
    int     idx;
    longint wg, op;
    longint q[4], p[3], n[3], t[3], rp[3], rn[3], rt[3];
    idx   = int'(w.bone_index);
    wg    = unit_clamp(longint'(w.blend_weight));
    emits = 1'b0;
    o     = '0;
    if (kind_t'(w.kind) == KIND_NONE) return;
    if (kind_t'(w.kind) == KIND_LOAD) begin
      pr_bpos[idx][0] = w.pos_x;
      pr_bpos[idx][1] = w.pos_y;
      pr_bpos[idx][2] = w.pos_z;
      pr_brot[idx][0] = int'(wg);
      pr_brot[idx][1] = int'(unit_clamp(longint'(w.norm_x)));
      pr_brot[idx][2] = int'(unit_clamp(longint'(w.norm_y)));
      pr_brot[idx][3] = int'(unit_clamp(longint'(w.norm_z)));
      return;
    end
    if (idx >= pr_count) begin
      pr_err = 1'b1;
    end else begin
      for (int i = 0; i < 4; i++) q[i] = pr_brot[idx][i];
      p = '{longint'(w.pos_x), longint'(w.pos_y), longint'(w.pos_z)};
      n = '{longint'(w.norm_x), longint'(w.norm_y), longint'(w.norm_z)};
      t = '{longint'(w.tan_x), longint'(w.tan_y), longint'(w.tan_z)};
      quat_rotate(q, p, rp);
      quat_rotate(q, n, rn);
      quat_rotate(q, t, rt);
      for (int i = 0; i < 3; i++) begin
        op = to32(rp[i] + pr_bpos[idx][i]);
        pr_spos[i] = to40(pr_spos[i] + fix_mul(wg, op));
        pr_snrm[i] = to40(pr_snrm[i] + fix_mul(wg, rn[i]));
        pr_stan[i] = to40(pr_stan[i] + fix_mul(wg, rt[i]));
      end
    end
    if (kind_t'(w.kind) != KIND_LAST) return;
    emits = 1'b1;
    o.out_pos_x  = 32'(to32(pr_spos[0]));
    o.out_pos_y  = 32'(to32(pr_spos[1]));
    o.out_pos_z  = 32'(to32(pr_spos[2]));
    o.out_norm_x = 32'(to32(pr_snrm[0]));
    o.out_norm_y = 32'(to32(pr_snrm[1]));
    o.out_norm_z = 32'(to32(pr_snrm[2]));
    o.out_tan_x  = 32'(to32(pr_stan[0]));
    o.out_tan_y  = 32'(to32(pr_stan[1]));
    o.out_tan_z  = 32'(to32(pr_stan[2]));
    o.bad_bone   = pr_err;
    pr_spos = '{0, 0, 0};
    pr_snrm = '{0, 0, 0};
    pr_stan = '{0, 0, 0};
    pr_err  = 1'b0;
  endtask

  // ------------------------------------------------------------------ monitor
  // Sample both handshakes at the edge; predict on input, check on output.
  always @(posedge clk) begin
    bit        emits;
    out_word_t predicted, want;
    if (rst_n && in_valid && in_ready) begin
      blend_word(in_data, emits, predicted);
      // where the table typed the answer in, that value is what must arrive
      if (emits) vertex_q.push_back(typed_on ? typed_word : predicted);
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_data);
      end else begin
        want = vertex_q.pop_front();
        if (out_data != want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p\n          actual   %p",
                                         want, out_data);
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when asked for one
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, vertex_q.size());
      $display("quaternion_skinning_blend test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic in_word_t make_word(kind_t k, int idx, int wg, int px, int py, int pz,
                                         int nx, int ny, int nz, int tx, int ty, int tz);
    in_word_t w;
    w.kind = k; w.bone_index = IDX_W'(idx); w.blend_weight = wg;
    w.pos_x = px; w.pos_y = py; w.pos_z = pz;
    w.norm_x = nx; w.norm_y = ny; w.norm_z = nz;
    w.tan_x = tx; w.tan_y = ty; w.tan_z = tz;
    return w;
  endfunction

  // unit-range value, now and then any 32-bit pattern (exercises the clamp)
  function automatic int rand_unit();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'sh4000_0000 : -32'sh4000_0000;
      default: return int'($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
    endcase
  endfunction

  function automatic int rand_pos();
    case ($urandom_range(7))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return int'($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t texp);
    // idle gaps first; valid then stays up until the word is taken
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= w;
    typed_on   <= typed;
    typed_word <= texp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (kind_t'(w.kind) == KIND_LAST) vertices_sent++;
  endtask

  task automatic send_plain(input in_word_t w);
    send_word(w, 1'b0, '0);
  endtask

  // hold the sender until every expected vertex has come back, then settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_bone_count(input int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CNT_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    pr_count = value;
  endtask

  task automatic rand_load();
    int idx;
    idx = $urandom_range(NBONES - 1);
    send_plain(make_word(KIND_LOAD, idx, rand_unit(), rand_pos(), rand_pos(), rand_pos(),
                         rand_unit(), rand_unit(), rand_unit(), $urandom, $urandom, $urandom));
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_q.push_back(idx);
    end
  endtask

  // a loaded bone, or now and then one at or above the bone count
  function automatic int pick_bone();
    if (pr_count < NBONES && $urandom_range(9) == 0)
      return $urandom_range(NBONES - 1, pr_count);
    return loaded_q[$urandom_range(loaded_q.size() - 1)];
  endfunction

  task automatic rand_vertex();
    int nw;
    nw = $urandom_range(4, 1);
    for (int i = 0; i < nw; i++)
      send_plain(make_word((i == nw - 1) ? KIND_LAST : KIND_WGT, pick_bone(), rand_unit(),
                           rand_pos(), rand_pos(), rand_pos(), rand_unit(), rand_unit(),
                           rand_unit(), rand_unit(), rand_unit(), rand_unit()));
  endtask

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } table_row_t;

  initial begin
    table_row_t rows[$];
    table_row_t row;
    out_word_t  r;
    int         counts[6];
    int         budget;

    counts = '{1024, 2047, 0, 1, 517, 1024};
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; cfg_we = 1'b0; cfg_wdata = '0;
    typed_on = 1'b0; typed_word = '0;
    mismatches = 0; results_seen = 0; words_sent = 0; vertices_sent = 0; cycles = 0;
    tx_idle_pct = 37; rx_idle_pct = 79; rx_hold_req = 0;
    pr_spos = '{0, 0, 0}; pr_snrm = '{0, 0, 0}; pr_stan = '{0, 0, 0};
    pr_err = 1'b0; pr_count = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; bone count is 1 out of reset
    // identity bone 0 at the origin: a unit weight passes vectors through
    row = '{make_word(KIND_LOAD, 0, 32'sh4000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0};
    rows.push_back(row);
    r = '{32'sh0001_0000, -32'sh0002_0000, 32'sh7fff_ffff, 32'sh4000_0000, -32'sh4000_0000,
          0, 0, 32'sh4000_0000, -32'sh4000_0000, 1'b0};
    row = '{make_word(KIND_LAST, 0, 32'sh4000_0000, 32'sh0001_0000, -32'sh0002_0000,
                      32'sh7fff_ffff, 32'sh4000_0000, -32'sh4000_0000, 0,
                      0, 32'sh4000_0000, -32'sh4000_0000), 1, r};
    rows.push_back(row);
    // bone 5 is beyond the count: empty vertex flagged
    r = '0;
    r.bad_bone = 1'b1;
    row = '{make_word(KIND_LAST, 5, 32'sh4000_0000, 1, 2, 3, 4, 5, 6, 7, 8, 9), 1, r};
    rows.push_back(row);
    // unused kind leaves everything alone
    row = '{make_word(KIND_NONE, 0, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom), 0, '0};
    rows.push_back(row);
    // zero weight contributes nothing
    r = '0;
    row = '{make_word(KIND_LAST, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, -1, 32'sh4000_0000,
                      1, -1, -32'sh4000_0000, 7, 9), 1, r};
    rows.push_back(row);
    // two unit weights at full position: sum past 32 bits, output saturates
    r = '0;
    r.out_pos_x = 32'sh7fff_ffff; r.out_pos_y = 32'sh8000_0000;
    row = '{make_word(KIND_WGT, 0, 32'sh4000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 0,
                      0, 0, 0, 0, 0, 0), 0, '0};
    rows.push_back(row);
    row = '{make_word(KIND_LAST, 0, 32'sh4000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 0,
                      0, 0, 0, 0, 0, 0), 1, r};
    rows.push_back(row);
    // out-of-range quaternion and weight get clamped; bone 0 reloaded with an offset
    row = '{make_word(KIND_LOAD, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 12345,
                      32'sh8000_0000, 32'sh7fff_ffff, 32'sh2000_0000, 0, 0, 0), 0, '0};
    rows.push_back(row);
    row = '{make_word(KIND_WGT, 0, 32'sh8000_0000, 32'sh7fff_ffff, -32'sh0123_4567,
                      32'sh0100_0000, 32'sh4000_0000, -32'sh4000_0000, 32'sh1234_5678,
                      32'sh7fff_ffff, 32'sh8000_0000, -32'sh4000_0000), 0, '0};
    rows.push_back(row);
    // mixed: invalid bone in the middle of a vertex still emits, flagged
    row = '{make_word(KIND_WGT, 1023, 32'sh2000_0000, 1, 1, 1, 1, 1, 1, 1, 1, 1), 0, '0};
    rows.push_back(row);
    row = '{make_word(KIND_LAST, 0, 32'sh3fff_ffff, -32'sh0001_0000, 32'sh0005_0000, 77,
                      -32'sh2000_0000, 32'sh1000_0000, 3, 5, -7, 32'sh4000_0000), 0, '0};
    rows.push_back(row);
    // load the top entry so the wide-count phases have a far bone
    row = '{make_word(KIND_LOAD, 1023, -32'sh4000_0000, -1, 32'sh7fff_ffff, 0,
                      32'sh0b50_4f33, -32'sh0b50_4f33, 0, $urandom, $urandom, $urandom),
            0, '0};
    rows.push_back(row);

    tx_idle_pct = 0; rx_idle_pct = 0;
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);
    drain();
    loaded[0] = 1'b1; loaded[1023] = 1'b1;
    loaded_q = '{0, 1023};

    // random phases: each changes the bone count while idle, then streams
    for (int ph = 0; ph < 6; ph++) begin
      write_bone_count(counts[ph]);
      tx_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 79 : 0;
      rx_idle_pct = (ph < 2) ? 79 : (ph < 4) ? 37 : 0;
      if (ph == 4) rx_hold_req = 400;  // long hold-off: block fills and backs up
      for (int k = 0; k < 16; k++) rand_load();
      budget = words_sent + 215;
      while (words_sent < budget) begin
        if (ph == 5 && words_sent + 100 == budget) drain();
        case ($urandom_range(19))
          0, 1:    rand_load();
          2:       send_plain(make_word(KIND_NONE, $urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom));
          default: rand_vertex();
        endcase
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    $display("sent %0d words (%0d vertices), checked %0d results across 6 bone counts",
             words_sent, vertices_sent, results_seen);
    $display("mismatches: %0d, results still outstanding: %0d", mismatches, vertex_q.size());
    if (mismatches == 0 && vertex_q.size() == 0) begin
      $display("quaternion_skinning_blend test passed");
    end else begin
      $display("quaternion_skinning_blend test failed");
    end
    $finish;
  end

endmodule

// File: quaternion_skinning_blend.f
rtl/qsb_pkg.sv
rtl/quaternion_skinning_blend.sv
tb/sv/quaternion_skinning_blend_test.sv
